[hw/rtl/rpn_pkg.sv]
// Shared types and constants for the reverse-Polish stack calculator.
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;

   typedef enum logic [3:0] {
      CMD_PUSH      = 4'd0,
      CMD_ADD       = 4'd1,
      CMD_SUB       = 4'd2,
      CMD_MUL       = 4'd3,
      CMD_PRINT     = 4'd4,
      CMD_PRINT_POP = 4'd5,
      CMD_CLEAR     = 4'd6,
      CMD_DUP       = 4'd7,
      CMD_PRINT_ALL = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OVER  = 2'd1,
      STAT_UNDER = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_OPREAD,
      ST_MULW,
      ST_PRINT,
      ST_DUPW,
      ST_WALK
   } state_type;

   typedef enum logic [1:0] {
      WR_PUSH,
      WR_ALU,
      WR_MUL,
      WR_DUP
   } wr_sel_type;

   typedef enum logic [1:0] {
      DEPTH_HOLD,
      DEPTH_INC,
      DEPTH_DEC,
      DEPTH_CLR
   } depth_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load_operand;
      logic         wr_en;
      wr_sel_type   wr_sel;
      depth_op_type depth_op;
      logic         ptr_load;
      logic         ptr_dec;
      logic         rd_walk;
      logic         alu_sub;
      logic         mul_load;
      logic         emit;
      logic         emit_zero;
      status_type   emit_status;
      logic         emit_last;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic below_two;
      logic full;
      logic walk_end;
   } dp_status_type;

endpackage

[hw/rtl/rpn_ctrl.sv]
// Controller state machine for the stack calculator.
module rpn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [3:0]            req_command,
   input  rpn_pkg::dp_status_type dp_status,
   output rpn_pkg::ctl_type      ctl,
   output logic                  busy
);
   import rpn_pkg::*;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= CMD_PUSH;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      ctl      = '0;
      busy     = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in           = cmd_type'(req_command);
               ctl.load_operand = 1'b1;
               state_in         = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            case (cmd_ff)
               CMD_PUSH: begin
                  if (dp_status.full) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_zero   = 1'b1;
                     ctl.emit_status = STAT_OVER;
                     ctl.emit_last   = 1'b1;
                  end else begin
                     ctl.wr_en    = 1'b1;
                     ctl.wr_sel   = WR_PUSH;
                     ctl.depth_op = DEPTH_INC;
                  end
               end
               CMD_ADD, CMD_SUB, CMD_MUL: begin
                  if (dp_status.below_two) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_zero   = 1'b1;
                     ctl.emit_status = STAT_UNDER;
                     ctl.emit_last   = 1'b1;
                  end else begin
                     state_in = ST_OPREAD;
                  end
               end
               CMD_PRINT, CMD_PRINT_POP: begin
                  if (dp_status.empty) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_zero   = 1'b1;
                     ctl.emit_status = STAT_UNDER;
                     ctl.emit_last   = 1'b1;
                  end else begin
                     state_in = ST_PRINT;
                  end
               end
               CMD_CLEAR: begin
                  ctl.depth_op = DEPTH_CLR;
               end
               CMD_DUP: begin
                  if (dp_status.empty || dp_status.full) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_zero   = 1'b1;
                     ctl.emit_status = dp_status.empty ? STAT_UNDER : STAT_OVER;
                     ctl.emit_last   = 1'b1;
                  end else begin
                     state_in = ST_DUPW;
                  end
               end
               CMD_PRINT_ALL: begin
                  if (dp_status.empty) begin
                     ctl.emit        = 1'b1;
                     ctl.emit_zero   = 1'b1;
                     ctl.emit_status = STAT_EMPTY;
                     ctl.emit_last   = 1'b1;
                  end else begin
                     ctl.ptr_load = 1'b1;
                     state_in     = ST_WALK;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_OPREAD: begin
            if (cmd_ff == CMD_MUL) begin
               ctl.mul_load = 1'b1;
               state_in     = ST_MULW;
            end else begin
               ctl.wr_en    = 1'b1;
               ctl.wr_sel   = WR_ALU;
               ctl.alu_sub  = (cmd_ff == CMD_SUB);
               ctl.depth_op = DEPTH_DEC;
               state_in     = ST_IDLE;
            end
         end
         ST_MULW: begin
            ctl.wr_en    = 1'b1;
            ctl.wr_sel   = WR_MUL;
            ctl.depth_op = DEPTH_DEC;
            state_in     = ST_IDLE;
         end
         ST_PRINT: begin
            ctl.emit        = 1'b1;
            ctl.emit_status = STAT_OK;
            ctl.emit_last   = 1'b1;
            ctl.depth_op    = (cmd_ff == CMD_PRINT_POP) ? DEPTH_DEC : DEPTH_HOLD;
            state_in        = ST_IDLE;
         end
         ST_DUPW: begin
            ctl.wr_en    = 1'b1;
            ctl.wr_sel   = WR_DUP;
            ctl.depth_op = DEPTH_INC;
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            ctl.emit        = 1'b1;
            ctl.emit_status = STAT_OK;
            ctl.emit_last   = dp_status.walk_end;
            ctl.rd_walk     = 1'b1;
            ctl.ptr_dec     = 1'b1;
            if (dp_status.walk_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/rpn_dpath.sv]
// Datapath of the stack calculator: stack memory, depth, ALU, multiplier, result register.
module rpn_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic signed [31:0]    req_operand_value,
   input  rpn_pkg::ctl_type      ctl,
   output rpn_pkg::dp_status_type dp_status,
   output logic                  rsp_strobe,
   output logic signed [31:0]    rsp_result_value,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last_of_run
);
   import rpn_pkg::*;

   logic [DATA_W-1:0]  mem [STACK_DEPTH];
   logic [DATA_W-1:0]  rd0_ff, rd1_ff;
   logic [DATA_W-1:0]  operand_ff;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic signed [2*DATA_W-1:0] prod_ff;

   logic               strobe_ff;
   logic [DATA_W-1:0]  value_ff;
   status_type         status_ff;
   logic               last_ff;

   logic [DEPTH_W-1:0] depth_m1, depth_m2;
   logic [ADDR_W-1:0]  rd_addr0, rd_addr1, wr_addr;
   logic [DATA_W-1:0]  wr_data;
   logic [DATA_W:0]    sum;
   logic [DATA_W-1:0]  alu_sat, mul_sat;
   logic [2*DATA_W-FRAC_W-1:0] prod_shr;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);
   assign rd_addr0 = ctl.rd_walk ? (ptr_ff - ADDR_W'(1)) : depth_m1[ADDR_W-1:0];
   assign rd_addr1 = depth_m2[ADDR_W-1:0];

   assign dp_status.empty     = (depth_ff == '0);
   assign dp_status.below_two = (depth_ff < DEPTH_W'(2));
   assign dp_status.full      = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign dp_status.walk_end  = (ptr_ff == '0);

   // Saturating add and subtract over a one-bit-wider sum.
   always_comb begin
      if (ctl.alu_sub) begin
         sum = {rd0_ff[DATA_W-1], rd0_ff} - {rd1_ff[DATA_W-1], rd1_ff};
      end else begin
         sum = {rd0_ff[DATA_W-1], rd0_ff} + {rd1_ff[DATA_W-1], rd1_ff};
      end
      if (sum[DATA_W] != sum[DATA_W-1]) begin
         alu_sat = sum[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
         alu_sat = sum[DATA_W-1:0];
      end
   end

   // Drop the fraction bits (floor) and clamp to the 32-bit range.
   always_comb begin
      prod_shr = prod_ff[2*DATA_W-1:FRAC_W];
      if ((&prod_shr[2*DATA_W-FRAC_W-1:DATA_W-1]) ||
          !(|prod_shr[2*DATA_W-FRAC_W-1:DATA_W-1])) begin
         mul_sat = prod_shr[DATA_W-1:0];
      end else begin
         mul_sat = prod_shr[2*DATA_W-FRAC_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_comb begin
      case (ctl.wr_sel)
         WR_PUSH: begin
            wr_data = operand_ff;
            wr_addr = depth_ff[ADDR_W-1:0];
         end
         WR_ALU: begin
            wr_data = alu_sat;
            wr_addr = depth_m2[ADDR_W-1:0];
         end
         WR_MUL: begin
            wr_data = mul_sat;
            wr_addr = depth_m2[ADDR_W-1:0];
         end
         WR_DUP: begin
            wr_data = rd0_ff;
            wr_addr = depth_ff[ADDR_W-1:0];
         end
         default: begin
            wr_data = operand_ff;
            wr_addr = depth_ff[ADDR_W-1:0];
         end
      endcase
   end

   always_comb begin
      case (ctl.depth_op)
         DEPTH_HOLD: depth_in = depth_ff;
         DEPTH_INC:  depth_in = depth_ff + DEPTH_W'(1);
         DEPTH_DEC:  depth_in = depth_m1;
         DEPTH_CLR:  depth_in = '0;
         default:    depth_in = depth_ff;
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.ptr_load) begin
         ptr_in = depth_m1[ADDR_W-1:0];
      end else if (ctl.ptr_dec) begin
         ptr_in = ptr_ff - ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff <= mem[rd_addr0];
      rd1_ff <= mem[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         strobe_ff <= ctl.emit;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctl.load_operand) begin
         operand_ff <= req_operand_value;
      end
      if (ctl.mul_load) begin
         prod_ff <= $signed(rd0_ff) * $signed(rd1_ff);
      end
      if (ctl.emit) begin
         value_ff  <= ctl.emit_zero ? '0 : rd0_ff;
         status_ff <= ctl.emit_status;
         last_ff   <= ctl.emit_last;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

[hw/rtl/rpn_stack_calculator.sv]
// Top level of the reverse-Polish stack calculator.
//
//   channel  | ports                                           | transfer when
//   ---------+-------------------------------------------------+-------------------
//   command  | start, busy, req_command, req_operand_value     | start && !busy
//   result   | rsp_strobe, rsp_result_value, rsp_status,       | rsp_strobe
//            | rsp_last_of_run                                 |
//
// A command transfers, then is decoded against the stack depth. Push, clear and errors
// finish in decode; print, print-pop, add, subtract and duplicate then do a registered
// stack read; multiply does a registered product, then shift and saturate; print-all
// reads its N entries, one entry read a cycle. Synchronous reset empties the stack; the
// memory is not cleared, as only entries below the depth are ever used. Results leave
// as one-cycle strobes; the receiver cannot stall.
module rpn_stack_calculator (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_command,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);
   import rpn_pkg::*;

   ctl_type       ctl;
   dp_status_type dp_status;

   // Sequence each command; hold busy until its last step is issued.
   rpn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .dp_status   (dp_status),
      .ctl         (ctl),
      .busy        (busy)
   );

   // Hold the stack and drive the result register.
   rpn_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operand_value (req_operand_value),
      .ctl               (ctl),
      .dp_status         (dp_status),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[hw/rtl/rpn_chk.sv]
// Port-level checker for the stack calculator, bound to the top level.
module rpn_chk (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic signed [31:0] rsp_result_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_strobe,
   input logic               rsp_last_of_run
);
   import rpn_pkg::*;

   // A transfer occupies the block for at least the decode cycle.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after command transfer");

   // Error results carry a zero value.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |-> (rsp_result_value == '0))
      else $error("error result with non-zero value");

   // Error results always end their run.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |-> rsp_last_of_run)
      else $error("error result not marked last");

   // A print-all run streams one entry per cycle until its last.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_of_run) |=> rsp_strobe)
      else $error("gap inside a print-all run");

endmodule

bind rpn_stack_calculator rpn_chk u_rpn_chk (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status),
   .rsp_strobe       (rsp_strobe),
   .rsp_last_of_run  (rsp_last_of_run)
);
